// ===== hdl/aph_pkg.sv =====
// ----------------------------------------------------------------------------
// aph_pkg
// Shared types, constants and hash helpers for the archive path hash block.
// ----------------------------------------------------------------------------
package aph_pkg;

  localparam int CharW = 7;
  localparam int LenW  = 16;
  localparam int HashW = 32;
  localparam int OutW  = 64;
  localparam int ExtKeep = 4;

  localparam logic [LenW-1:0] LenMax = 16'hFFFF;

  // path characters
  localparam logic [CharW-1:0] ChSlash = 7'h2F;
  localparam logic [CharW-1:0] ChBack  = 7'h5C;
  localparam logic [CharW-1:0] ChUpA   = 7'h41;
  localparam logic [CharW-1:0] ChUpZ   = 7'h5A;
  localparam logic [CharW-1:0] ChDot   = 7'h2E;
  localparam logic [CharW-1:0] ChK     = 7'h6B;
  localparam logic [CharW-1:0] ChF     = 7'h66;
  localparam logic [CharW-1:0] ChN     = 7'h6E;
  localparam logic [CharW-1:0] ChI     = 7'h69;
  localparam logic [CharW-1:0] ChD     = 7'h64;
  localparam logic [CharW-1:0] ChS     = 7'h73;
  localparam logic [CharW-1:0] ChW     = 7'h77;
  localparam logic [CharW-1:0] ChA     = 7'h61;
  localparam logic [CharW-1:0] ChV     = 7'h76;

  // extension flag bits
  localparam logic [HashW-1:0] FlagKf  = 32'h0000_0080;
  localparam logic [HashW-1:0] FlagNif = 32'h0000_8000;
  localparam logic [HashW-1:0] FlagDds = 32'h0000_8080;
  localparam logic [HashW-1:0] FlagWav = 32'h8000_0000;

  // accumulated state of one path, also the snapshot handed to the final stage
  typedef struct packed {
    logic [LenW-1:0]               name_len;
    logic [CharW-1:0]              first_char;
    logic [CharW-1:0]              dly0;
    logic [CharW-1:0]              dly1;
    logic [HashW-1:0]              name_hash;
    logic [HashW-1:0]              ext_hash;
    logic [ExtKeep-1:0][CharW-1:0] ext_chars;
    logic [LenW-1:0]               ext_len;
  } aph_state_t;

  // ascii lowercase
  function automatic logic [CharW-1:0] to_lower(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= ChUpA && c <= ChUpZ) r = c + 7'd32;
    return r;
  endfunction

  // h * 0x1003f + c as shift-add, modulo 2^32
  function automatic logic [HashW-1:0] hash_step(input logic [HashW-1:0] h,
                                                 input logic [CharW-1:0] c);
    return (h << 16) + (h << 6) - h + {{(HashW-CharW){1'b0}}, c};
  endfunction

endpackage

// ===== hdl/aph_accum.sv =====
// ----------------------------------------------------------------------------
// aph_accum
// Per-character state update and end-of-path snapshot register.
// ----------------------------------------------------------------------------
module aph_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  input  logic [aph_pkg::CharW-1:0] item_ch,
  input  logic                      item_is_ext,
  input  logic                      item_has_char,
  input  logic                      item_last,
  output logic                      item_take,
  input  logic                      snap_ready,
  output logic                      snap_valid,
  output aph_pkg::aph_state_t       snap
);
  import aph_pkg::*;

  aph_state_t       state_r;
  aph_state_t       state_nxt;
  aph_state_t       snap_r;
  logic             snap_valid_r;
  logic [CharW-1:0] name_c;
  logic [CharW-1:0] ext_c;

  // a last word waits for room in the snapshot register
  assign item_take = item_valid && (!item_last || snap_ready);

  // next state for the word in the input register
  always_comb begin
    name_c    = to_lower((item_ch == ChSlash) ? ChBack : item_ch);
    ext_c     = to_lower(item_ch);
    state_nxt = state_r;
    if (item_has_char && !item_is_ext) begin
      if (state_r.name_len >= 16'd3) begin
        state_nxt.name_hash = hash_step(state_r.name_hash, state_r.dly1);
      end
      state_nxt.dly1 = state_r.dly0;
      state_nxt.dly0 = name_c;
      if (state_r.name_len == '0) state_nxt.first_char = name_c;
      if (state_r.name_len != LenMax) state_nxt.name_len = state_r.name_len + 16'd1;
    end else if (item_has_char) begin
      state_nxt.ext_hash = hash_step(state_r.ext_hash, ext_c);
      if (state_r.ext_len < 16'(ExtKeep)) begin
        state_nxt.ext_chars[state_r.ext_len[1:0]] = ext_c;
      end
      if (state_r.ext_len != LenMax) state_nxt.ext_len = state_r.ext_len + 16'd1;
    end
  end

  // running state, cleared after each path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (item_take) begin
      state_r <= item_last ? '0 : state_nxt;
    end
  end

  // snapshot of a finished path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (snap_ready) begin
      snap_valid_r <= item_take && item_last;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item_last) begin
      snap_r <= state_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

// ===== hdl/aph_final.sv =====
// ----------------------------------------------------------------------------
// aph_final
// Builds the 64-bit hash from a path snapshot and holds it for the receiver.
// ----------------------------------------------------------------------------
module aph_final (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     snap_valid,
  input  aph_pkg::aph_state_t      snap,
  output logic                     snap_ready,
  output logic                     out_valid,
  output logic [aph_pkg::OutW-1:0] out_hash,
  input  logic                     out_stall
);
  import aph_pkg::*;

  logic             out_valid_r;
  logic [OutW-1:0]  hash_r;
  logic [OutW-1:0]  hash_nxt;
  logic [HashW-1:0] low;
  logic [HashW-1:0] flags;
  logic             is_kf;
  logic             is_nif;
  logic             is_dds;
  logic             is_wav;
  logic             len4;

  assign snap_ready = !out_valid_r || !out_stall;

  // extension match, exact length and characters
  always_comb begin
    len4   = (snap.ext_len == 16'd4);
    is_kf  = (snap.ext_len == 16'd3) && snap.ext_chars[0] == ChDot &&
             snap.ext_chars[1] == ChK && snap.ext_chars[2] == ChF;
    is_nif = len4 && snap.ext_chars[0] == ChDot && snap.ext_chars[1] == ChN &&
             snap.ext_chars[2] == ChI && snap.ext_chars[3] == ChF;
    is_dds = len4 && snap.ext_chars[0] == ChDot && snap.ext_chars[1] == ChD &&
             snap.ext_chars[2] == ChD && snap.ext_chars[3] == ChS;
    is_wav = len4 && snap.ext_chars[0] == ChDot && snap.ext_chars[1] == ChW &&
             snap.ext_chars[2] == ChA && snap.ext_chars[3] == ChV;
    priority if (is_kf) begin
      flags = FlagKf;
    end else if (is_nif) begin
      flags = FlagNif;
    end else if (is_dds) begin
      flags = FlagDds;
    end else if (is_wav) begin
      flags = FlagWav;
    end else begin
      flags = '0;
    end
  end

  // low word from kept characters, length and extension flags, high word from the two hashes
  always_comb begin
    low = {25'd0, snap.dly0};
    if (snap.name_len >= 16'd3) low = low | {17'd0, snap.dly1, 8'd0};
    low = low | {snap.name_len, 16'd0} | {1'b0, snap.first_char, 24'd0};
    if (snap.name_len == '0) begin
      hash_nxt = '0;
    end else begin
      hash_nxt = {snap.name_hash + snap.ext_hash, low | flags};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_ready) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      hash_r <= hash_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hash  = hash_r;

endmodule

// ===== hdl/archive_path_hash.sv =====
// ----------------------------------------------------------------------------
// archive_path_hash
// Streaming archive file-name hash, one path character per word.
// ----------------------------------------------------------------------------
// The input channel carries one character per word: name characters with
// in_is_extension low, extension characters (dot included) with it high,
// in_has_char low for a word that carries no character, and in_last on the
// final word of a path. Only a last word produces a result: one 64-bit word
// on out_hash. A path with an empty name hashes to 0.
// A new word is accepted every cycle while in_stall is low. From the last word to
// out_valid a path passes the input register, the character update with path
// snapshot, and the result register that assembles the final hash. The character
// update, one shift-add multiply per cycle, sets the one-word-per-cycle rate.
// When the receiver stalls, the result register holds; further character
// words keep flowing until a path end reaches the input register, where it
// waits for the stall to clear, and in_stall is raised behind it.
// Synchronous reset clears all path state and empties every stage; after
// reset the block is ready at once.
// ----------------------------------------------------------------------------
module archive_path_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [aph_pkg::CharW-1:0] in_ch,
  input  logic                      in_is_extension,
  input  logic                      in_has_char,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [aph_pkg::OutW-1:0]  out_hash
);
  import aph_pkg::*;

  logic             s1_valid_r;
  logic [CharW-1:0] s1_ch_r;
  logic             s1_is_ext_r;
  logic             s1_has_char_r;
  logic             s1_last_r;
  logic             s1_take;
  logic             s1_ready;
  logic             snap_ready;
  logic             snap_valid;
  aph_state_t       snap;

  assign s1_ready = !s1_valid_r || s1_take;
  assign in_stall = !s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_ch_r       <= in_ch;
      s1_is_ext_r   <= in_is_extension;
      s1_has_char_r <= in_has_char;
      s1_last_r     <= in_last;
    end
  end

  // character update and path snapshot
  aph_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (s1_valid_r),
    .item_ch       (s1_ch_r),
    .item_is_ext   (s1_is_ext_r),
    .item_has_char (s1_has_char_r),
    .item_last     (s1_last_r),
    .item_take     (s1_take),
    .snap_ready    (snap_ready),
    .snap_valid    (snap_valid),
    .snap          (snap)
  );

  // final hash and result register
  aph_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_valid  (out_valid),
    .out_hash   (out_hash),
    .out_stall  (out_stall)
  );

endmodule

// ===== hdl/aph_checker.sv =====
// ----------------------------------------------------------------------------
// aph_checker
// Port-level checks for the archive path hash block, bound to the top level.
// ----------------------------------------------------------------------------
module aph_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [aph_pkg::CharW-1:0] in_ch,
  input logic                      in_is_extension,
  input logic                      in_has_char,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [aph_pkg::OutW-1:0]  out_hash
);

  logic acc_last;

  assign acc_last = in_valid && !in_stall && in_last;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hash))
    else $error("stalled result changed");

  // reset empties the block and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // a path end with a free-running receiver shows its result after the input, snapshot and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc_last ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after path end");

  // an idle input with nothing pending is never stalled by an idle output
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(!out_valid, 2) &&
    $past(!in_valid) && $past(!in_valid, 2) |-> !in_stall)
    else $error("input stalled while block is empty");

endmodule

bind archive_path_hash aph_checker u_aph_checker (.*);

// ===== tb/archive_path_hash_tb.sv =====
// ----------------------------------------------------------------------------
// archive_path_hash_tb
// Self-checking bench for the streaming archive path hash. Paths go in one
// character word at a time under random source gaps and sink stalls; every
// accepted word also steps a local hash predictor, and each result word is
// compared with the oldest predicted hash.
// ----------------------------------------------------------------------------
module archive_path_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aph_pkg::*;

  localparam int ClkPeriod  = 20;
  localparam int WatchLimit = 5000;
  localparam int HoldCycles = 400;

  // known extension kinds
  typedef enum int {
    ExtKindKf,
    ExtKindNif,
    ExtKindDds,
    ExtKindWav
  } ext_kind_e;

  // running state of one path in the predictor
  typedef struct packed {
    logic [LenW-1:0]               nlen;
    logic [CharW-1:0]              first;
    logic [CharW-1:0]              tail0;
    logic [CharW-1:0]              tail1;
    logic [HashW-1:0]              nhash;
    logic [HashW-1:0]              ehash;
    logic [ExtKeep-1:0][CharW-1:0] echars;
    logic [LenW-1:0]               elen;
  } path_acc_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             ext;
    logic             has;
    logic             last;
  } path_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CharW-1:0] in_ch = '0;
  logic             in_is_extension = 1'b0;
  logic             in_has_char = 1'b0;
  logic             in_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OutW-1:0]  out_hash;

  path_acc_t        acc = '0;
  logic [OutW-1:0]  hash_expected[$];
  int               mismatch_cnt = 0;
  int               src_idle_pct = 0;
  int               sink_idle_pct = 0;
  int               hold_gen = 0;
  int               hold_seen = 0;
  int               hold_left = 0;

  archive_path_hash u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_is_extension (in_is_extension),
    .in_has_char     (in_has_char),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash        (out_hash)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    if (c >= ChUpA && c <= ChUpZ) return c + 7'd32;
    return c;
  endfunction

  function automatic bit ext_is(input path_acc_t a, input int n,
                                input logic [CharW-1:0] c0, input logic [CharW-1:0] c1,
                                input logic [CharW-1:0] c2, input logic [CharW-1:0] c3);
    if (a.elen != LenW'(n)) return 1'b0;
    if (a.echars[0] != c0 || a.echars[1] != c1 || a.echars[2] != c2) return 1'b0;
    if (n == 4 && a.echars[3] != c3) return 1'b0;
    return 1'b1;
  endfunction

  // assemble the 64-bit hash from a finished path
  function automatic logic [OutW-1:0] compose_hash(input path_acc_t a);
    logic [OutW-1:0] r;
    if (a.nlen == 0) return '0;
    r = {57'd0, a.tail0};
    if (a.nlen >= 3) r = r | ({57'd0, a.tail1} << 8);
    r = r | ({48'd0, a.nlen} << 16);
    r = r | ({57'd0, a.first} << 24);
    r = r + {a.nhash, 32'd0};
    if (a.elen == 0) return r;
    if (ext_is(a, 3, ChDot, ChK, ChF, ChF)) r = r | {32'd0, FlagKf};
    else if (ext_is(a, 4, ChDot, ChN, ChI, ChF)) r = r | {32'd0, FlagNif};
    else if (ext_is(a, 4, ChDot, ChD, ChD, ChS)) r = r | {32'd0, FlagDds};
    else if (ext_is(a, 4, ChDot, ChW, ChA, ChV)) r = r | {32'd0, FlagWav};
    r = r + {a.ehash, 32'd0};
    return r;
  endfunction

  // step the path state by one accepted word, queue the hash on a path end
  function automatic void advance_path(input logic [CharW-1:0] ch, input logic ext,
                                       input logic has, input logic last);
    logic [CharW-1:0] c;
    c = ch;
    if (has && !ext) begin
      if (c == ChSlash) c = ChBack;
      c = fold_case(c);
      if (acc.nlen >= 3) acc.nhash = acc.nhash * 32'h0001_003f + {25'd0, acc.tail1};
      acc.tail1 = acc.tail0;
      acc.tail0 = c;
      if (acc.nlen == 0) acc.first = c;
      if (acc.nlen != LenMax) acc.nlen = acc.nlen + 1'b1;
    end else if (has) begin
      c = fold_case(c);
      acc.ehash = acc.ehash * 32'h0001_003f + {25'd0, c};
      if (acc.elen < ExtKeep) acc.echars[acc.elen[1:0]] = c;
      if (acc.elen != LenMax) acc.elen = acc.elen + 1'b1;
    end
    if (last) begin
      hash_expected.push_back(compose_hash(acc));
      acc = '0;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  // predict on accepted input words, compare accepted result words
  always @(posedge clk) begin : check_b
    logic [OutW-1:0] want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        advance_path(in_ch, in_is_extension, in_has_char, in_last);
      end
      if (out_valid && !out_stall) begin
        if (hash_expected.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result word: hash %h", out_hash);
        end else begin
          want = hash_expected.pop_front();
          if (out_hash !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("hash mismatch: expected %h, actual %h", want, out_hash);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // random sink stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------- sender

  // offer one word, with random gaps first, and hold it until taken
  task automatic send_word(input logic [CharW-1:0] ch, input logic ext,
                           input logic has, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      in_ch    <= CharW'($urandom);
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_ch           <= ch;
    in_is_extension <= ext;
    in_has_char     <= has;
    in_last         <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic ext, input logic last_on_end);
    for (int i = 0; i < s.len(); i++) begin
      send_word(CharW'(s[i]), ext, 1'b1, last_on_end && (i == s.len() - 1));
    end
  endtask

  task automatic end_path();
    send_word(CharW'($urandom), 1'($urandom), 1'b0, 1'b1);
  endtask

  function automatic logic [CharW-1:0] rand_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return ChUpA + CharW'($urandom_range(25));
    if (pick < 55) return ChA + CharW'($urandom_range(25));
    if (pick < 70) return ChSlash;
    if (pick < 78) return ChBack;
    return CharW'($urandom_range(127));
  endfunction

  // known extension, letters in random case
  task automatic push_known_ext(input ext_kind_e kind, inout logic [CharW-1:0] q[$]);
    string s;
    case (kind)
      ExtKindKf:  s = ".kf";
      ExtKindNif: s = ".nif";
      ExtKindDds: s = ".dds";
      default:    s = ".wav";
    endcase
    for (int i = 0; i < s.len(); i++) begin
      if (i > 0 && $urandom_range(1)) q.push_back(CharW'(s[i]) - 7'd32);
      else q.push_back(CharW'(s[i]));
    end
  endtask

  // build one random path: mostly well formed, some broken or noisy
  task automatic build_path(output path_word_t words[$]);
    logic [CharW-1:0] name_q[$];
    logic [CharW-1:0] ext_q[$];
    path_word_t       w;
    int               nlen;
    int               pick;
    bit               mix;
    words = {};
    pick = $urandom_range(99);
    if (pick < 5) nlen = 0;
    else if (pick < 85) nlen = $urandom_range(1, 12);
    else nlen = $urandom_range(13, 40);
    for (int i = 0; i < nlen; i++) name_q.push_back(rand_char());
    pick = $urandom_range(99);
    if (pick < 50) begin
      push_known_ext(ext_kind_e'($urandom_range(3)), ext_q);
    end else if (pick < 65) begin
      // near miss: one char short or one too many
      push_known_ext(ext_kind_e'($urandom_range(3)), ext_q);
      if ($urandom_range(1)) void'(ext_q.pop_back());
      else ext_q.push_back(rand_char());
    end else if (pick < 80) begin
      ext_q.push_back(ChDot);
      repeat ($urandom_range(0, 6)) ext_q.push_back(CharW'($urandom_range(127)));
    end
    mix = ($urandom_range(99) < 15);
    while (name_q.size() > 0 || ext_q.size() > 0) begin
      // noise word with no character
      if ($urandom_range(99) < 5) begin
        w = '{ch: CharW'($urandom), ext: 1'($urandom), has: 1'b0, last: 1'b0};
        words.push_back(w);
      end
      if (name_q.size() > 0 && (!mix || ext_q.size() == 0 || $urandom_range(1))) begin
        w = '{ch: name_q.pop_front(), ext: 1'b0, has: 1'b1, last: 1'b0};
      end else begin
        w = '{ch: ext_q.pop_front(), ext: 1'b1, has: 1'b1, last: 1'b0};
      end
      words.push_back(w);
    end
    if (words.size() == 0 || $urandom_range(99) < 15) begin
      w = '{ch: CharW'($urandom), ext: 1'($urandom), has: 1'b0, last: 1'b1};
      words.push_back(w);
    end else begin
      words[words.size() - 1].last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_paths();
    end_path();
    send_text(".dds", 1'b1, 1'b0);
    end_path();
  endtask

  task automatic test_short_names();
    send_text("A", 1'b0, 1'b1);
    send_text("bZ", 1'b0, 1'b0);
    end_path();
    send_text("a/C", 1'b0, 1'b1);
    send_text("d/e\\", 1'b0, 1'b1);
  endtask

  task automatic test_char_extremes();
    send_word(7'h00, 1'b0, 1'b1, 1'b0);
    send_word(7'h7F, 1'b0, 1'b1, 1'b0);
    send_word(7'h7F, 1'b1, 1'b1, 1'b0);
    send_word(7'h7F, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_extension_flags();
    send_text("x", 1'b0, 1'b0);
    send_text(".KF", 1'b1, 1'b1);
    send_text("y", 1'b0, 1'b0);
    send_text(".nif", 1'b1, 1'b1);
    send_text("z", 1'b0, 1'b0);
    send_text(".DdS", 1'b1, 1'b1);
    send_text("w", 1'b0, 1'b0);
    send_text(".wav", 1'b1, 1'b1);
    send_text("v", 1'b0, 1'b0);
    send_text(".ddsx", 1'b1, 1'b1);
  endtask

  task automatic test_interleaved();
    send_text("ab", 1'b0, 1'b0);
    send_text(".n", 1'b1, 1'b0);
    send_word(7'h55, 1'b1, 1'b0, 1'b0);
    send_text("cd", 1'b0, 1'b0);
    send_text("if", 1'b1, 1'b0);
    send_text("E", 1'b0, 1'b1);
  endtask

  // long sink hold-off while short paths keep coming, so the input backs up
  task automatic test_backpressure();
    hold_gen++;
    repeat (12) send_text("abc", 1'b0, 1'b1);
  endtask

  task automatic test_random_paths(input int budget);
    path_word_t words[$];
    int         sent;
    sent = 0;
    while (sent < budget) begin
      build_path(words);
      foreach (words[i]) begin
        send_word(words[i].ch, words[i].ext, words[i].has, words[i].last);
        if (words[i].has) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 10;
    sink_idle_pct = 55;
    test_empty_paths();
    test_short_names();
    test_char_extremes();
    test_extension_flags();
    test_interleaved();
    test_random_paths(320);

    src_idle_pct  = 55;
    sink_idle_pct = 10;
    test_backpressure();
    test_random_paths(320);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_paths(320);

    @(negedge clk);
    in_valid <= 1'b0;
    while (hash_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && hash_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
